// File: design/brle_pkg.sv
// Package for the bit run-length encoder.
// Holds the queue entry and head types and the run limit; no dependencies.
package brle_pkg;

  localparam int BYTE_W = 8;
  localparam int CNT_W  = 7;
  localparam int IDX_W  = 3;

  localparam logic [CNT_W-1:0] MAX_RUN = 7'd127;

  typedef enum logic {
    CMD_DATA  = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_t;

  typedef struct packed {
    logic              is_flush;
    logic [BYTE_W-1:0] data_byte;
    logic [BYTE_W-1:0] change_mask;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } head_t;

endpackage

// File: design/brle_if.sv
// Channel interfaces for the bit run-length encoder.
// Depends on brle_pkg for the field widths.
interface brle_in_if;
  import brle_pkg::*;
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [BYTE_W-1:0] data_byte;
  modport source (output valid, output cmd, output data_byte, input ready);
  modport sink (input valid, input cmd, input data_byte, output ready);
endinterface

interface brle_out_if;
  import brle_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] code_byte;
  logic              last;
  modport source (output valid, output code_byte, output last, input ready);
  modport sink (input valid, input code_byte, input last, output ready);
endinterface

// File: design/brle_front.sv
// Front part: accepts input items, marks bit changes and queues them.
// Depends on brle_pkg and brle_in_if.
module brle_front (
  input  logic            clk,
  input  logic            rst_n,
  brle_in_if.sink         in_ch,
  input  logic            pop,
  output brle_pkg::head_t head
);
  import brle_pkg::*;

  entry_t     mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] fill_r;
  logic [1:0] fill_nxt;
  logic       push;
  logic       do_pop;
  entry_t     new_entry;

  always_comb begin
    new_entry.is_flush    = (cmd_t'(in_ch.cmd) == CMD_FLUSH);
    new_entry.data_byte   = in_ch.data_byte;
    new_entry.change_mask = {in_ch.data_byte[BYTE_W-1:1] ^ in_ch.data_byte[BYTE_W-2:0], 1'b0};
  end

  assign in_ch.ready = (fill_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign do_pop      = pop && (fill_r != 2'd0);
  assign head.valid  = (fill_r != 2'd0);
  assign head.entry  = mem_r[rd_ptr_r];

  always_comb begin
    fill_nxt = fill_r;
    if (push && !do_pop) begin
      fill_nxt = fill_r + 2'd1;
    end else if (!push && do_pop) begin
      fill_nxt = fill_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= new_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      fill_r <= fill_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r != 2'd3)
    else $error("queue fill count out of range");

  a_ptr_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r == 2'd1) |-> (wr_ptr_r != rd_ptr_r))
    else $error("queue pointers disagree with fill count");

  a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head.valid)
    else $error("pop requested from an empty queue");

endmodule

// File: design/brle_back.sv
// Back part: walks each queued byte one bit per cycle, holding a bit whose code
// finds the output register busy; tracks runs. Depends on brle_pkg and brle_out_if.
module brle_back (
  input  logic            clk,
  input  logic            rst_n,
  input  brle_pkg::head_t head,
  output logic            pop,
  brle_out_if.source      out_ch
);
  import brle_pkg::*;

  logic              run_bit_r;
  logic              run_bit_nxt;
  logic [CNT_W-1:0]  run_count_r;
  logic [CNT_W-1:0]  run_count_nxt;
  logic              started_r;
  logic              started_nxt;
  logic [IDX_W-1:0]  bit_idx_r;
  logic              out_valid_r;
  logic [BYTE_W-1:0] code_r;
  logic              last_r;
  logic              cur_bit;
  logic              emit;
  logic              emit_last;
  logic              out_free;
  logic              step;
  logic [BYTE_W-1:0] later;

  assign cur_bit  = head.entry.data_byte[bit_idx_r];
  assign later    = head.entry.change_mask >> bit_idx_r;
  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    run_bit_nxt   = run_bit_r;
    run_count_nxt = run_count_r;
    started_nxt   = started_r;
    if (head.entry.is_flush) begin
      emit          = started_r && (run_count_r != '0);
      emit_last     = 1'b1;
      run_bit_nxt   = 1'b0;
      run_count_nxt = '0;
      started_nxt   = 1'b0;
    end else begin
      emit        = started_r && ((run_bit_r != cur_bit) || (run_count_r == MAX_RUN));
      emit_last   = (later[BYTE_W-1:1] == '0);
      run_bit_nxt = cur_bit;
      started_nxt = 1'b1;
      if (emit || !started_r) begin
        run_count_nxt = CNT_W'(1);
      end else begin
        run_count_nxt = run_count_r + CNT_W'(1);
      end
    end
  end

  assign step = head.valid && (!emit || out_free);
  assign pop  = step && (head.entry.is_flush || (bit_idx_r == IDX_W'(BYTE_W - 1)));

  assign out_ch.valid     = out_valid_r;
  assign out_ch.code_byte = code_r;
  assign out_ch.last      = last_r;

  always_ff @(posedge clk) begin
    if (step && emit) begin
      code_r <= {run_bit_r, run_count_r};
      last_r <= emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_bit_r   <= 1'b0;
      run_count_r <= '0;
      started_r   <= 1'b0;
      bit_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (step) begin
        run_bit_r   <= run_bit_nxt;
        run_count_r <= run_count_nxt;
        started_r   <= started_nxt;
        if (pop) begin
          bit_idx_r <= '0;
        end else begin
          bit_idx_r <= bit_idx_r + IDX_W'(1);
        end
      end
      if (step && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    started_r |-> (run_count_r != '0))
    else $error("active run has zero length");

  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !started_r |-> (run_count_r == '0))
    else $error("run length held without a started run");

  a_code_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (code_r[CNT_W-1:0] != '0))
    else $error("code with zero run length");

  a_mid_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (bit_idx_r != '0) |-> (head.valid && !head.entry.is_flush))
    else $error("bit walk in progress without a data byte at the head");

endmodule

// File: design/bit_run_length_encoder_core.sv
// Bit run-length encoder. A data byte is walked one bit per cycle, least
// significant bit first. The single bit-serial run tracker sets this rate,
// and a two-entry queue lets new items be accepted while a byte is being
// walked. A code is emitted on a change of bit value or when a run reaches
// 127 bits, and the tracker pauses on a bit that emits only while the output
// register is full and not being taken. The last code of each item carries
// last high. Depends on brle_pkg, brle_if, brle_front and brle_back.
module bit_run_length_encoder_core (
  input  logic    clk,
  input  logic    rst_n,
  brle_in_if.sink     in_ch,
  brle_out_if.source  out_ch
);
  import brle_pkg::*;

  head_t head;
  logic  pop;

  brle_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .pop   (pop),
    .head  (head)
  );

  brle_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule
